// ===== sv/paged_mmu_map_load_store_defines.svh =====
`ifndef PAGED_MMU_MAP_LOAD_STORE_DEFINES_SVH
`define PAGED_MMU_MAP_LOAD_STORE_DEFINES_SVH

// Concurrent check, muted while reset is held
`define PMM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent check that also runs across reset
`define PMM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== sv/pmm_pkg.sv =====
`timescale 1ns / 1ps

package pmm_pkg;

  // Fixed field widths of the request and result channels
  localparam int ACTION_W  = 2;
  localparam int PROC_ID_W = 2;
  localparam int VADDR_W   = 8;
  localparam int DATA_W    = 8;
  localparam int STATUS_W  = 3;

  // Widest classified fields over the supported parameter ranges
  localparam int MAX_ENTRY_BITS  = 12;
  localparam int MAX_PROC_BITS   = 6;
  localparam int MAX_OFFSET_BITS = 12;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_MAP   = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_STORE = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_MAP  = 3'd1,
    ST_NO_TABLE = 3'd2,
    ST_NO_DATA  = 3'd3,
    ST_FAULT    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_RUN,
    BK_LOAD
  } back_state_t;

  // Request after decode, as it waits in the queue
  typedef struct packed {
    act_t                       op;
    logic                       in_range;
    logic [MAX_PROC_BITS-1:0]   proc_idx;
    logic [MAX_ENTRY_BITS-1:0]  entry_idx;
    logic [MAX_OFFSET_BITS-1:0] offset;
    logic                       writable;
    logic [DATA_W-1:0]          data;
  } item_t;

endpackage

// ===== sv/pmm_if.sv =====
`timescale 1ns / 1ps

interface pmm_in_if;
  logic                           valid;
  logic                           ready;
  logic [pmm_pkg::ACTION_W-1:0]   action;
  logic [pmm_pkg::PROC_ID_W-1:0]  proc_id;
  logic [pmm_pkg::VADDR_W-1:0]    vaddr;
  logic                           make_writable;
  logic [pmm_pkg::DATA_W-1:0]     store_data;

  modport source (output valid, action, proc_id, vaddr, make_writable, store_data,
                  input ready);
  modport sink   (input valid, action, proc_id, vaddr, make_writable, store_data,
                  output ready);
endinterface

interface pmm_out_if;
  logic                          valid;
  logic                          ready;
  logic [pmm_pkg::STATUS_W-1:0]  status;
  logic [pmm_pkg::DATA_W-1:0]    load_data;

  modport source (output valid, status, load_data, input ready);
  modport sink   (input valid, status, load_data, output ready);
endinterface

// ===== sv/pmm_ram.sv =====
`timescale 1ns / 1ps

module pmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; rdata holds when re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pmm_front.sv =====
`timescale 1ns / 1ps

module pmm_front #(
  parameter int OFFSET_BITS = 4,
  parameter int VIRT_PAGES  = 4,
  parameter int PROC_COUNT  = 4
) (
  pmm_in_if.sink          in_req,
  input  logic            accept_en,
  output logic            push_valid,
  input  logic            push_ready,
  output pmm_pkg::item_t  push_item
);

  localparam int EB = pmm_pkg::MAX_ENTRY_BITS;
  localparam int PB = pmm_pkg::MAX_PROC_BITS;
  localparam int OB = pmm_pkg::MAX_OFFSET_BITS;

  logic [pmm_pkg::VADDR_W-1:0] vpage;
  logic [OFFSET_BITS-1:0]      offset;
  logic                        vpage_ok;
  logic                        proc_ok;
  int                          entry;

  // Handshake: pass straight into the queue, closed during the clear pass
  assign push_valid   = in_req.valid && accept_en;
  assign in_req.ready = push_ready && accept_en;

  // Split the address and check the ranges
  always_comb begin
    vpage    = in_req.vaddr >> OFFSET_BITS;
    offset   = OFFSET_BITS'(in_req.vaddr);
    vpage_ok = int'(vpage) < VIRT_PAGES;
    proc_ok  = int'(in_req.proc_id) < PROC_COUNT;
    entry    = int'(in_req.proc_id) * VIRT_PAGES + int'(vpage);

    push_item.op        = pmm_pkg::act_t'(in_req.action);
    push_item.in_range  = vpage_ok && proc_ok;
    push_item.proc_idx  = PB'(in_req.proc_id);
    push_item.entry_idx = EB'(entry);
    push_item.offset    = OB'(offset);
    push_item.writable  = in_req.make_writable;
    push_item.data      = in_req.store_data;
  end

endmodule

// ===== sv/pmm_queue.sv =====
`timescale 1ns / 1ps

module pmm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  pmm_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output pmm_pkg::item_t  pop_item
);

  localparam int DEPTH = pmm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pmm_pkg::item_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/pmm_back.sv =====
`timescale 1ns / 1ps

module pmm_back #(
  parameter int OFFSET_BITS = 4,
  parameter int VIRT_PAGES  = 4,
  parameter int NUM_FRAMES  = 4,
  parameter int PROC_COUNT  = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  pmm_pkg::item_t  pop_item,
  pmm_out_if.source       out_rsp,
  output logic            clearing
);

  localparam int FW        = $clog2(NUM_FRAMES);
  localparam int CW        = $clog2(NUM_FRAMES + 1);
  localparam int AW        = FW + OFFSET_BITS;
  localparam int MEM_DEPTH = NUM_FRAMES << OFFSET_BITS;
  localparam int ENTRIES   = PROC_COUNT * VIRT_PAGES;
  localparam int EW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW        = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
  localparam int DW        = pmm_pkg::DATA_W;

  typedef struct packed {
    logic          valid;
    logic          writable;
    logic [FW-1:0] frame;
  } entry_t;

  pmm_pkg::back_state_t   state_r, state_nxt;
  entry_t                 entry_r [ENTRIES];
  entry_t                 entry_nxt [ENTRIES];
  logic [PROC_COUNT-1:0]  table_r, table_nxt;
  logic [CW-1:0]          alloc_r, alloc_nxt;
  logic [AW-1:0]          clr_addr_r, clr_addr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  pmm_pkg::status_t       out_status_r, out_status_nxt;
  logic [DW-1:0]          out_data_r, out_data_nxt;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [DW-1:0]          ram_wdata, ram_rdata;

  logic [EW-1:0]          eidx;
  logic [PW-1:0]          pidx;
  logic [OFFSET_BITS-1:0] off;
  entry_t                 cur;
  logic                   tp, need_t, need_d, hit_rd, hit_wr, slot_free;
  logic [CW-1:0]          cnt1;
  logic [AW-1:0]          byte_addr;

  pmm_ram #(
    .WIDTH (DW),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Table lookup for the request at the queue head
  always_comb begin
    eidx      = EW'(pop_item.entry_idx);
    pidx      = PW'(pop_item.proc_idx);
    off       = OFFSET_BITS'(pop_item.offset);
    cur       = entry_r[eidx];
    tp        = table_r[pidx];
    need_t    = !tp;
    need_d    = !cur.valid;
    cnt1      = alloc_r + CW'(need_t);
    hit_rd    = pop_item.in_range && tp && cur.valid;
    hit_wr    = hit_rd && cur.writable;
    byte_addr = {cur.frame, off};
    slot_free = !out_valid_r || out_rsp.ready;
  end

  // Clear pass, then one request per cycle if slot_free and not in BK_LOAD
  always_comb begin
    state_nxt      = state_r;
    entry_nxt      = entry_r;
    table_nxt      = table_r;
    alloc_nxt      = alloc_r;
    clr_addr_nxt   = clr_addr_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    pop_ready      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = byte_addr;
    ram_wdata      = pop_item.data;
    ram_re         = 1'b0;
    ram_raddr      = byte_addr;

    case (state_r)
      pmm_pkg::BK_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MEM_DEPTH - 1)) begin
          state_nxt = pmm_pkg::BK_RUN;
        end
      end

      pmm_pkg::BK_RUN: begin
        if (pop_valid && slot_free) begin
          pop_ready      = 1'b1;
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '0;
          out_status_nxt = pmm_pkg::ST_FAULT;
          case (pop_item.op)
            pmm_pkg::ACT_MAP: begin
              if (!pop_item.in_range) begin
                out_status_nxt = pmm_pkg::ST_BAD_MAP;
              end else if (need_t && alloc_r == CW'(NUM_FRAMES)) begin
                out_status_nxt = pmm_pkg::ST_NO_TABLE;
              end else begin
                table_nxt[pidx] = 1'b1;
                alloc_nxt       = cnt1;
                if (need_d && cnt1 == CW'(NUM_FRAMES)) begin
                  out_status_nxt = pmm_pkg::ST_NO_DATA;
                end else begin
                  entry_nxt[eidx].valid    = 1'b1;
                  entry_nxt[eidx].writable = pop_item.writable;
                  if (need_d) begin
                    entry_nxt[eidx].frame = FW'(cnt1);
                    alloc_nxt             = cnt1 + 1'b1;
                  end
                  out_status_nxt = pmm_pkg::ST_OK;
                end
              end
            end
            pmm_pkg::ACT_LOAD: begin
              if (hit_rd) begin
                ram_re        = 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = pmm_pkg::BK_LOAD;
              end
            end
            pmm_pkg::ACT_STORE: begin
              if (hit_wr) begin
                ram_we         = 1'b1;
                out_status_nxt = pmm_pkg::ST_OK;
              end
            end
            default: begin
              out_status_nxt = pmm_pkg::ST_FAULT;
            end
          endcase
        end
      end

      pmm_pkg::BK_LOAD: begin
        // output register was emptied when the read went out
        out_valid_nxt  = 1'b1;
        out_status_nxt = pmm_pkg::ST_OK;
        out_data_nxt   = ram_rdata;
        state_nxt      = pmm_pkg::BK_RUN;
      end

      default: begin
        state_nxt = pmm_pkg::BK_CLEAR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pmm_pkg::BK_CLEAR;
      entry_r     <= '{default: '0};
      table_r     <= '0;
      alloc_r     <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      entry_r     <= entry_nxt;
      table_r     <= table_nxt;
      alloc_r     <= alloc_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = out_status_r;
  assign out_rsp.load_data = out_data_r;
  assign clearing          = state_r == pmm_pkg::BK_CLEAR;

endmodule

// ===== sv/paged_mmu_map_load_store.sv =====
`timescale 1ns / 1ps

// Paged memory unit: per-process single-level page tables over a small
// physical byte memory of NUM_FRAMES pages of 2^OFFSET_BITS bytes each.
// in_req carries map, load and store requests (valid/ready); out_rsp returns
// exactly one result per request, in order, with status and load_data.
// A request is decoded on its way into a two-entry queue; the back end takes
// one request from the queue head per cycle while the output slot is free
// and no load is in flight. A map, store or faulting request goes from the
// queue head to the output register; a successful load first reads the byte
// memory through its registered read port, and the back end takes no new
// request until the byte is back. After reset the byte memory is zeroed one
// byte per cycle, all NUM_FRAMES << OFFSET_BITS bytes (64 at the defaults);
// in_req.ready stays low until it is done. Tables and page allocation are
// cleared at once. When out_rsp stalls, the result holds in the output
// register, the back end waits, and the queue keeps taking requests until
// it is full.
module paged_mmu_map_load_store #(
  parameter int OFFSET_BITS = 4,
  parameter int VIRT_PAGES  = 4,
  parameter int NUM_FRAMES  = 4,
  parameter int PROC_COUNT  = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  pmm_in_if.sink    in_req,
  pmm_out_if.source out_rsp
);

  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  logic           clearing;
  pmm_pkg::item_t push_item, pop_item;

  pmm_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .VIRT_PAGES  (VIRT_PAGES),
    .PROC_COUNT  (PROC_COUNT)
  ) u_front (
    .in_req     (in_req),
    .accept_en  (!clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  pmm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  pmm_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .VIRT_PAGES  (VIRT_PAGES),
    .NUM_FRAMES  (NUM_FRAMES),
    .PROC_COUNT  (PROC_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_rsp   (out_rsp),
    .clearing  (clearing)
  );

endmodule

// ===== sv/pmm_checker.sv =====
`timescale 1ns / 1ps
`include "paged_mmu_map_load_store_defines.svh"

module pmm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pmm_pkg::STATUS_W-1:0]  out_status,
  input logic [pmm_pkg::DATA_W-1:0]    out_load_data
);

  // A stalled result stays offered
  `PMM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // ... and does not change under the stall
  `PMM_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_status) && $stable(out_load_data), "stalled result changed")

  // Only a successful load carries a byte
  `PMM_ASSERT(a_fail_zero, out_valid && (out_status != pmm_pkg::ST_OK) |-> out_load_data == '0, "failed request returned data")

  // Right after reset the memory clear is running: no requests, no results
  `PMM_ASSERT_RST(a_reset_quiet, !$past(rst_n) |-> !in_ready && !out_valid, "activity right after reset")

endmodule

bind paged_mmu_map_load_store pmm_checker u_pmm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_req.ready),
  .out_valid     (out_rsp.valid),
  .out_ready     (out_rsp.ready),
  .out_status    (out_rsp.status),
  .out_load_data (out_rsp.load_data)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int OFFSET_BITS = 4;
  localparam int VIRT_PAGES  = 4;
  localparam int NUM_FRAMES  = 4;
  localparam int PROC_COUNT  = 4;
  localparam int FRAME_W     = $clog2(NUM_FRAMES);
  localparam int PAGE_BYTES  = 1 << OFFSET_BITS;
  localparam int OFFSET_MASK = PAGE_BYTES - 1;
  localparam int RANDOM_REQS = 1500;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 10;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    pmm_pkg::status_t           status;
    logic [pmm_pkg::DATA_W-1:0] data;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic               writable;
    logic [FRAME_W-1:0] frame;
  } pte_t;

  typedef struct {
    pmm_pkg::act_t                 act;
    logic [pmm_pkg::PROC_ID_W-1:0] proc;
    logic [pmm_pkg::VADDR_W-1:0]   va;
    logic                          wr;
    logic [pmm_pkg::DATA_W-1:0]    data;
    bit                            typed;
    pmm_pkg::status_t              status;
    logic [pmm_pkg::DATA_W-1:0]    load;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pmm_in_if  in_req();
  pmm_out_if out_rsp();

  paged_mmu_map_load_store #(
    .OFFSET_BITS(OFFSET_BITS),
    .VIRT_PAGES (VIRT_PAGES),
    .NUM_FRAMES (NUM_FRAMES),
    .PROC_COUNT (PROC_COUNT)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the paging state
  logic [pmm_pkg::DATA_W-1:0] shadow_bytes [NUM_FRAMES*PAGE_BYTES];
  pte_t                       shadow_pte [PROC_COUNT*VIRT_PAGES];
  bit                         table_ready [PROC_COUNT];
  bit                         frame_used [NUM_FRAMES];

  result_t pending_results[$];
  int      fail_count;
  int      requests_sent;
  int      results_seen;
  int      ok_count;
  int      fault_count;
  int      alloc_err_count;
  bit      no_idle;

  function automatic int unsigned lowest_free_frame();
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (!frame_used[i]) return i;
    end
    return NUM_FRAMES;
  endfunction

  // Applies one request to the shadow state and returns the result it gives
  function automatic result_t apply_request(pmm_pkg::act_t act,
                                            logic [pmm_pkg::PROC_ID_W-1:0] proc,
                                            logic [pmm_pkg::VADDR_W-1:0] va, logic wr,
                                            logic [pmm_pkg::DATA_W-1:0] data);
    result_t     res;
    int unsigned vpage;
    int unsigned idx;
    int unsigned frame;
    int unsigned addr;
    bit          need_write;
    res.status = pmm_pkg::ST_FAULT;
    res.data   = '0;
    vpage      = va >> OFFSET_BITS;
    idx        = proc * VIRT_PAGES + vpage;
    case (act)
      pmm_pkg::ACT_MAP: begin
        if (vpage >= VIRT_PAGES || proc >= PROC_COUNT) begin
          res.status = pmm_pkg::ST_BAD_MAP;
        end else begin
          res.status = pmm_pkg::ST_OK;
          // table page first, then the data page
          if (!table_ready[proc]) begin
            frame = lowest_free_frame();
            if (frame >= NUM_FRAMES) begin
              res.status = pmm_pkg::ST_NO_TABLE;
            end else begin
              frame_used[frame] = 1'b1;
              table_ready[proc] = 1'b1;
            end
          end
          if (res.status == pmm_pkg::ST_OK && !shadow_pte[idx].valid) begin
            frame = lowest_free_frame();
            if (frame >= NUM_FRAMES) begin
              res.status = pmm_pkg::ST_NO_DATA;
            end else begin
              frame_used[frame]     = 1'b1;
              shadow_pte[idx].frame = FRAME_W'(frame);
              shadow_pte[idx].valid = 1'b1;
            end
          end
          if (res.status == pmm_pkg::ST_OK) shadow_pte[idx].writable = wr;
        end
      end
      pmm_pkg::ACT_LOAD, pmm_pkg::ACT_STORE: begin
        need_write = (act == pmm_pkg::ACT_STORE);
        if (vpage < VIRT_PAGES && proc < PROC_COUNT && table_ready[proc] &&
            shadow_pte[idx].valid && !(need_write && !shadow_pte[idx].writable)) begin
          addr = (int'(shadow_pte[idx].frame) << OFFSET_BITS) | (va & OFFSET_MASK);
          if (need_write) shadow_bytes[addr] = data;
          else res.data = shadow_bytes[addr];
          res.status = pmm_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offer one request after a random gap; predict once it is accepted
  task automatic issue_request(pmm_pkg::act_t act, logic [pmm_pkg::PROC_ID_W-1:0] proc,
                               logic [pmm_pkg::VADDR_W-1:0] va, logic wr,
                               logic [pmm_pkg::DATA_W-1:0] data,
                               bit typed, result_t typed_res);
    int      gap;
    result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid         <= 1'b1;
    in_req.action        <= act;
    in_req.proc_id       <= proc;
    in_req.vaddr         <= va;
    in_req.make_writable <= wr;
    in_req.store_data    <= data;
    do @(posedge clk); while (!in_req.ready);
    res = apply_request(act, proc, va, wr, data);
    pending_results.push_back(typed ? typed_res : res);
    requests_sent++;
  endtask

  // Result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      results_seen++;
      case (out_rsp.status)
        pmm_pkg::ST_OK:    ok_count++;
        pmm_pkg::ST_FAULT: fault_count++;
        default:           alloc_err_count++;
      endcase
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: status %0d load_data %02h",
                   out_rsp.status, out_rsp.load_data);
      end else begin
        want = pending_results.pop_front();
        if (out_rsp.status !== want.status || out_rsp.load_data !== want.data) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result %0d: status exp %0d got %0d, load_data exp %02h got %02h",
                     results_seen, want.status, out_rsp.status, want.data,
                     out_rsp.load_data);
        end
      end
    end
  end

  // Result side: random stalls, one long hold-off to back the block up
  initial begin
    int stall;
    int taken;
    taken = 0;
    out_rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (taken == HOLD_AT) begin
        out_rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_rsp.valid));
      taken++;
    end
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // Stimulus
  initial begin
    stim_row_t                     directed_rows [25];
    result_t                       typed_res;
    pmm_pkg::act_t                 act;
    logic [pmm_pkg::PROC_ID_W-1:0] proc;
    logic [pmm_pkg::VADDR_W-1:0]   va;
    logic                          wr;
    logic [pmm_pkg::DATA_W-1:0]    data;
    int unsigned                   pick;

    fail_count      = 0;
    requests_sent   = 0;
    results_seen    = 0;
    ok_count        = 0;
    fault_count     = 0;
    alloc_err_count = 0;
    no_idle         = 1'b0;
    for (int i = 0; i < NUM_FRAMES*PAGE_BYTES; i++) shadow_bytes[i] = '0;
    for (int i = 0; i < PROC_COUNT*VIRT_PAGES; i++) shadow_pte[i] = '0;
    for (int i = 0; i < PROC_COUNT; i++) table_ready[i] = 1'b0;
    for (int i = 0; i < NUM_FRAMES; i++) frame_used[i] = 1'b0;

    rst_n                <= 1'b0;
    in_req.valid         <= 1'b0;
    in_req.action        <= pmm_pkg::ACT_MAP;
    in_req.proc_id       <= '0;
    in_req.vaddr         <= '0;
    in_req.make_writable <= 1'b0;
    in_req.store_data    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // act, proc, vaddr, wr, data, typed, status, load_data
    directed_rows = '{
      // access before any table exists
      '{pmm_pkg::ACT_LOAD,  2'd0, 8'h00, 1'b0, 8'h00, 1'b1, pmm_pkg::ST_FAULT,    8'h00},
      '{pmm_pkg::ACT_STORE, 2'd0, 8'h00, 1'b0, 8'hFF, 1'b1, pmm_pkg::ST_FAULT,    8'h00},
      // map past the virtual range, no table taken
      '{pmm_pkg::ACT_MAP,   2'd0, 8'h40, 1'b1, 8'h00, 1'b1, pmm_pkg::ST_BAD_MAP,  8'h00},
      '{pmm_pkg::ACT_MAP,   2'd3, 8'hFF, 1'b0, 8'hFF, 1'b1, pmm_pkg::ST_BAD_MAP,  8'h00},
      '{pmm_pkg::ACT_LOAD,  2'd2, 8'hFF, 1'b1, 8'h00, 1'b1, pmm_pkg::ST_FAULT,    8'h00},
      // unused action code
      '{pmm_pkg::ACT_NONE,  2'd1, 8'h00, 1'b1, 8'hFF, 1'b1, pmm_pkg::ST_FAULT,    8'h00},
      // table in page 0, data in page 1
      '{pmm_pkg::ACT_MAP,   2'd0, 8'h00, 1'b1, 8'h00, 1'b1, pmm_pkg::ST_OK,       8'h00},
      '{pmm_pkg::ACT_STORE, 2'd0, 8'h05, 1'b0, 8'hFF, 1'b1, pmm_pkg::ST_OK,       8'h00},
      '{pmm_pkg::ACT_LOAD,  2'd0, 8'h05, 1'b0, 8'h00, 1'b0, pmm_pkg::ST_OK,       8'h00},
      '{pmm_pkg::ACT_LOAD,  2'd0, 8'h0F, 1'b0, 8'h00, 1'b0, pmm_pkg::ST_OK,       8'h00},
      // read-only page, store must fault
      '{pmm_pkg::ACT_MAP,   2'd0, 8'h3F, 1'b0, 8'h00, 1'b1, pmm_pkg::ST_OK,       8'h00},
      '{pmm_pkg::ACT_STORE, 2'd0, 8'h3F, 1'b1, 8'hAA, 1'b1, pmm_pkg::ST_FAULT,    8'h00},
      '{pmm_pkg::ACT_LOAD,  2'd0, 8'h3F, 1'b0, 8'h00, 1'b0, pmm_pkg::ST_OK,       8'h00},
      // remap of a mapped page only changes the permission
      '{pmm_pkg::ACT_MAP,   2'd0, 8'h30, 1'b1, 8'h00, 1'b1, pmm_pkg::ST_OK,       8'h00},
      '{pmm_pkg::ACT_STORE, 2'd0, 8'h30, 1'b0, 8'h5A, 1'b1, pmm_pkg::ST_OK,       8'h00},
      '{pmm_pkg::ACT_LOAD,  2'd0, 8'h10, 1'b0, 8'h00, 1'b1, pmm_pkg::ST_FAULT,    8'h00},
      // table takes the last page, nothing left for data
      '{pmm_pkg::ACT_MAP,   2'd1, 8'h20, 1'b1, 8'h00, 1'b1, pmm_pkg::ST_NO_DATA,  8'h00},
      '{pmm_pkg::ACT_MAP,   2'd2, 8'h00, 1'b1, 8'h00, 1'b1, pmm_pkg::ST_NO_TABLE, 8'h00},
      '{pmm_pkg::ACT_MAP,   2'd1, 8'h10, 1'b0, 8'h00, 1'b1, pmm_pkg::ST_NO_DATA,  8'h00},
      '{pmm_pkg::ACT_LOAD,  2'd1, 8'h20, 1'b0, 8'h00, 1'b1, pmm_pkg::ST_FAULT,    8'h00},
      '{pmm_pkg::ACT_STORE, 2'd1, 8'h20, 1'b1, 8'h11, 1'b1, pmm_pkg::ST_FAULT,    8'h00},
      '{pmm_pkg::ACT_LOAD,  2'd0, 8'h30, 1'b0, 8'h00, 1'b0, pmm_pkg::ST_OK,       8'h00},
      '{pmm_pkg::ACT_STORE, 2'd0, 8'h00, 1'b1, 8'h00, 1'b0, pmm_pkg::ST_OK,       8'h00},
      '{pmm_pkg::ACT_LOAD,  2'd0, 8'h00, 1'b0, 8'h00, 1'b0, pmm_pkg::ST_OK,       8'h00},
      '{pmm_pkg::ACT_MAP,   2'd3, 8'hC0, 1'b1, 8'h00, 1'b1, pmm_pkg::ST_BAD_MAP,  8'h00}
    };

    foreach (directed_rows[i]) begin
      typed_res.status = directed_rows[i].status;
      typed_res.data   = directed_rows[i].load;
      issue_request(directed_rows[i].act, directed_rows[i].proc, directed_rows[i].va,
                    directed_rows[i].wr, directed_rows[i].data, directed_rows[i].typed,
                    typed_res);
    end

    // Random part: mostly traffic to the pages that stay mapped, some noise
    typed_res = '0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      no_idle = (n >= 800 && n < 1000);
      pick    = $urandom_range(0, 99);
      if (pick < 75) begin
        pick = $urandom_range(0, 99);
        act  = (pick < 15) ? pmm_pkg::ACT_MAP :
               (pick < 60) ? pmm_pkg::ACT_LOAD : pmm_pkg::ACT_STORE;
        proc = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
        va   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 63))
                                          : {($urandom_range(0, 1) ? 4'd3 : 4'd0),
                                             4'($urandom_range(0, 15))};
      end else begin
        act  = pmm_pkg::act_t'($urandom_range(0, 3));
        proc = 2'($urandom_range(0, 3));
        va   = 8'($urandom_range(0, 255));
      end
      wr   = 1'($urandom_range(0, 1));
      data = 8'($urandom_range(0, 255));
      issue_request(act, proc, va, wr, data, 1'b0, typed_res);
    end
    in_req.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d requests (map, load, store, unused code) with random gaps and a long",
             requests_sent);
    $display("result stall; %0d results: %0d ok, %0d faults, %0d map errors",
             results_seen, ok_count, fault_count, alloc_err_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
